>>> design/fri_pkg.sv
// ----------------------------------------------------------------------------
// fri_pkg
// Shared types and constants of the frame reorder injector: default sizes,
// count and lfsr constants, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package fri_pkg;

  // default sizes handed to the top level parameters
  localparam int HOLD_DEPTH_DEF  = 8;
  localparam int HANDLE_BITS_DEF = 8;

  // held counts
  localparam int              COUNT_W   = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // shuffle lfsr (galois, shifting right)
  localparam int               LFSR_W     = 16;
  localparam logic [LFSR_W-1:0] LFSR_RESET = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_MATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHUFFLE     = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_SCAN_RD,
    ST_SCAN_WR,
    ST_DRAW,
    ST_DIV,
    ST_SW_RD_I,
    ST_SW_RD_J,
    ST_SW_WR_I,
    ST_SW_WR_J,
    ST_PASS,
    ST_EMIT_RD,
    ST_EMIT_WR
  } fri_state_t;

endpackage

>>> design/fri_ram.sv
// ----------------------------------------------------------------------------
// fri_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module fri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/fri_mod.sv
// ----------------------------------------------------------------------------
// fri_mod
// Serial remainder unit: one restoring step per cycle over the lfsr word,
// gives draw modulo divisor for the shuffle.
// ----------------------------------------------------------------------------
module fri_mod #(
  parameter int DIV_W = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [fri_pkg::LFSR_W-1:0] dividend,
  input  logic [DIV_W-1:0]          divisor,
  output logic                      done,
  output logic [DIV_W-1:0]          rem
);
  import fri_pkg::*;

  localparam int STEP_W = $clog2(LFSR_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [LFSR_W-1:0] quot;
  logic [DIV_W-1:0]  dsr;
  logic [DIV_W-1:0]  rem_acc;
  logic [DIV_W:0]    trial;
  logic              fits;

  // one restoring step: shift in next dividend bit, subtract if it fits
  assign trial = {rem_acc, quot[LFSR_W-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign rem   = rem_acc;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(LFSR_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quot    <= dividend;
      dsr     <= divisor;
      rem_acc <= '0;
    end else if (busy) begin
      quot    <= quot << 1;
      rem_acc <= fits ? DIV_W'(trial - {1'b0, dsr}) : DIV_W'(trial);
    end
  end

endmodule

>>> design/frame_reorder_injector.sv
// ----------------------------------------------------------------------------
// frame_reorder_injector
// Holds selected frames in a small slot store and reinjects them once enough
// frames have passed, in slot order or in an lfsr-shuffled order.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------------
//  frame    | in        | frame_valid / frame_stall  | frame_handle, stream_match,
//           |           |                            | take_request
//  result   | out       | result_valid / result_stall| out_handle, reinjected, last_of_run
//  cfg      | in        | cfg_write                  | cfg_index, cfg_data
//
//  A held frame waits in a first-free slot search (ST_FIND).
//  A passed frame runs the count/release scan (a read and a write state per slot),
//  then per shuffle swap a draw, the serial remainder unit, two reads and two
//  writes, then the passed result, then each released result, read and then
//  written out through the single read port of the batch memory.
//  Reset (rst, synchronous) clears slot valid bits and registers and reloads
//  the lfsr seed.
//  A stalled result holds the sequencer in its pass or emit state; frame_stall
//  is high whenever the sequencer is away from idle.
// ----------------------------------------------------------------------------
module frame_reorder_injector #(
  parameter int HOLD_DEPTH  = fri_pkg::HOLD_DEPTH_DEF,
  parameter int HANDLE_BITS = fri_pkg::HANDLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // frame channel
  input  logic                          frame_valid,
  output logic                          frame_stall,
  input  logic [HANDLE_BITS-1:0]        frame_handle,
  input  logic                          stream_match,
  input  logic                          take_request,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [HANDLE_BITS-1:0]        out_handle,
  output logic                          reinjected,
  output logic                          last_of_run,
  // configuration
  input  logic                          cfg_write,
  input  logic [fri_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fri_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fri_pkg::*;

  localparam int SLOT_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CNT_W  = $clog2(HOLD_DEPTH + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HOLD_DEPTH - 1);

  // configuration registers
  logic [COUNT_W-1:0] thr;
  logic               cmo;
  logic               shuf;

  // sequencer and working registers
  fri_state_t          state, state_next;
  logic [HOLD_DEPTH-1:0] held_valid;
  logic [SLOT_W-1:0]   idx;
  logic [CNT_W-1:0]    n;
  logic [CNT_W-1:0]    k;
  logic [CNT_W-1:0]    shuf_i;
  logic [SLOT_W-1:0]   shuf_j;
  logic [HANDLE_BITS-1:0] tmp_i;
  logic [HANDLE_BITS-1:0] cur_handle;
  logic                cur_match;
  logic [LFSR_W-1:0]   lfsr;
  logic [LFSR_W-1:0]   lfsr_next;

  // memory ports
  logic                   hram_we;
  logic [HANDLE_BITS-1:0] hram_rdata;
  logic                   cram_we;
  logic [COUNT_W-1:0]     cram_wdata;
  logic [COUNT_W-1:0]     cram_rdata;
  logic                   bram_we;
  logic [SLOT_W-1:0]      bram_waddr;
  logic [HANDLE_BITS-1:0] bram_wdata;
  logic [SLOT_W-1:0]      bram_raddr;
  logic [HANDLE_BITS-1:0] bram_rdata;

  // remainder unit
  logic             div_start;
  logic             div_done;
  logic [CNT_W-1:0] div_rem;

  // scan helpers
  logic               any_free;
  logic               cnt_en;
  logic [COUNT_W-1:0] cnt_new;
  logic               rel;
  logic [CNT_W-1:0]   n_after;
  logic               out_free;
  logic               out_load;
  logic [HANDLE_BITS-1:0] load_handle;
  logic               load_reinj;
  logic               load_last;
  logic               emit_last;

  assign frame_stall = (state != ST_IDLE);
  assign any_free    = ~&held_valid;
  assign cnt_en      = !cmo || cur_match;
  assign cnt_new     = (cnt_en && cram_rdata != COUNT_MAX) ? cram_rdata + 1'b1 : cram_rdata;
  assign rel         = held_valid[idx] && (cnt_new >= thr);
  assign n_after     = n + CNT_W'(rel);
  assign out_free    = !result_valid || !result_stall;
  assign emit_last   = (k == n - 1'b1);
  assign lfsr_next   = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);

  // slot stores and release batch
  fri_ram #(.WIDTH(HANDLE_BITS), .DEPTH(HOLD_DEPTH)) u_handle_ram (
    .clk   (clk),
    .we    (hram_we),
    .waddr (idx),
    .wdata (cur_handle),
    .raddr (idx),
    .rdata (hram_rdata)
  );

  fri_ram #(.WIDTH(COUNT_W), .DEPTH(HOLD_DEPTH)) u_count_ram (
    .clk   (clk),
    .we    (cram_we),
    .waddr (idx),
    .wdata (cram_wdata),
    .raddr (idx),
    .rdata (cram_rdata)
  );

  fri_ram #(.WIDTH(HANDLE_BITS), .DEPTH(HOLD_DEPTH)) u_batch_ram (
    .clk   (clk),
    .we    (bram_we),
    .waddr (bram_waddr),
    .wdata (bram_wdata),
    .raddr (bram_raddr),
    .rdata (bram_rdata)
  );

  fri_mod #(.DIV_W(CNT_W)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (lfsr_next),
    .divisor  (shuf_i + 1'b1),
    .done     (div_done),
    .rem      (div_rem)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory / unit controls
  always_comb begin
    state_next  = state;
    hram_we     = 1'b0;
    cram_we     = 1'b0;
    cram_wdata  = '0;
    bram_we     = 1'b0;
    bram_waddr  = n[SLOT_W-1:0];
    bram_wdata  = hram_rdata;
    bram_raddr  = k[SLOT_W-1:0];
    div_start   = 1'b0;
    out_load    = 1'b0;
    load_handle = bram_rdata;
    load_reinj  = 1'b1;
    load_last   = emit_last;
    unique case (state)
      ST_IDLE: begin
        if (frame_valid) begin
          state_next = (stream_match && take_request && any_free) ? ST_FIND : ST_SCAN_RD;
        end
      end
      ST_FIND: begin
        if (!held_valid[idx]) begin
          hram_we    = 1'b1;
          cram_we    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        state_next = ST_SCAN_WR;
      end
      ST_SCAN_WR: begin
        cram_we    = held_valid[idx];
        cram_wdata = cnt_new;
        bram_we    = rel;
        if (idx == LAST_SLOT) begin
          state_next = (shuf && n_after > CNT_W'(1)) ? ST_DRAW : ST_PASS;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_DRAW: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SW_RD_I;
        end
      end
      ST_SW_RD_I: begin
        bram_raddr = shuf_i[SLOT_W-1:0];
        state_next = ST_SW_RD_J;
      end
      ST_SW_RD_J: begin
        bram_raddr = shuf_j;
        state_next = ST_SW_WR_I;
      end
      ST_SW_WR_I: begin
        bram_we    = 1'b1;
        bram_waddr = shuf_i[SLOT_W-1:0];
        bram_wdata = bram_rdata;
        state_next = ST_SW_WR_J;
      end
      ST_SW_WR_J: begin
        bram_we    = 1'b1;
        bram_waddr = shuf_j;
        bram_wdata = tmp_i;
        state_next = (shuf_i == CNT_W'(1)) ? ST_PASS : ST_DRAW;
      end
      ST_PASS: begin
        load_handle = cur_handle;
        load_reinj  = 1'b0;
        load_last   = (n == '0);
        if (out_free) begin
          out_load   = 1'b1;
          state_next = (n == '0) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration, valid bits and lfsr
  always_ff @(posedge clk) begin
    if (rst) begin
      thr        <= '0;
      cmo        <= 1'b0;
      shuf       <= 1'b0;
      held_valid <= '0;
      lfsr       <= LFSR_RESET;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_THRESHOLD:   thr  <= cfg_data[COUNT_W-1:0];
          REG_COUNT_MATCH: cmo  <= cfg_data[0];
          REG_SHUFFLE:     shuf <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == ST_FIND && !held_valid[idx]) begin
        held_valid[idx] <= 1'b1;
      end
      if (state == ST_SCAN_WR && rel) begin
        held_valid[idx] <= 1'b0;
      end
      if (state == ST_DRAW) begin
        lfsr <= lfsr_next;
      end
    end
  end

  // working registers of one item
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        idx        <= '0;
        n          <= '0;
        cur_handle <= frame_handle;
        cur_match  <= stream_match;
      end
      ST_FIND: begin
        if (held_valid[idx]) begin
          idx <= idx + 1'b1;
        end
      end
      ST_SCAN_WR: begin
        n      <= n_after;
        shuf_i <= n_after - 1'b1;
        if (idx != LAST_SLOT) begin
          idx <= idx + 1'b1;
        end
      end
      ST_DIV: begin
        shuf_j <= div_rem[SLOT_W-1:0];
      end
      ST_SW_RD_J: begin
        tmp_i <= bram_rdata;
      end
      ST_SW_WR_J: begin
        shuf_i <= shuf_i - 1'b1;
      end
      ST_PASS: begin
        k <= '0;
      end
      ST_EMIT_WR: begin
        if (out_free) begin
          k <= k + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_handle  <= load_handle;
      reinjected  <= load_reinj;
      last_of_run <= load_last;
    end
  end

`ifndef SYNTHESIS
  // an accepted item always takes the sequencer away from idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_stall |=> frame_stall)
    else $error("frame_stall low right after an accepted item");

  // back in idle, a waiting result can only be the last one of its run
  a_idle_pending_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && result_valid |-> last_of_run)
    else $error("result pending in idle is not last of run");

  // shuffle draw never points past the current position
  a_draw_in_range: assert property (@(posedge clk) disable iff (rst)
    div_done |-> div_rem <= shuf_i)
    else $error("shuffle draw beyond current position");

  // the release scan only ever frees slots
  a_scan_frees_only: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN_WR |=> $countones(held_valid) <= $past($countones(held_valid)))
    else $error("slot became valid during release scan");
`endif

endmodule

>>> verif/tb_frame_reorder_injector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_reorder_injector
// Self-checking bench for the frame reorder injector. A tracker class keeps
// its own copy of the hold slots, counts and shuffle lfsr, works out the
// result items of each accepted frame and checks them in order on the
// result channel. Directed frames cover the corners first (full slots, zero
// and maximum threshold, counting on matching frames only, a full shuffled
// batch); random frames then run under changing settings and idle patterns,
// with one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_frame_reorder_injector;
  import fri_pkg::*;

  localparam int HB            = HANDLE_BITS_DEF;
  localparam int DEPTH         = HOLD_DEPTH_DEF;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 39;

  // tracks held frames and the result items they are due to produce
  class reinject_tracker;
    typedef struct {
      logic [HB-1:0] handle;
      logic          reinj;
      logic          last;
    } out_item_t;

    logic [COUNT_W-1:0] threshold;
    logic               count_match_only;
    logic               shuffle_on;
    logic [HB-1:0]      slot_handle [DEPTH];
    logic [COUNT_W-1:0] slot_count [DEPTH];
    logic               slot_busy [DEPTH];
    logic [31:0]        taken_total;
    logic [LFSR_W-1:0]  lfsr_state;
    out_item_t          due_outputs [$];
    int                 mismatches;

    function new();
      threshold        = '0;
      count_match_only = 1'b0;
      shuffle_on       = 1'b0;
      foreach (slot_busy[i]) begin
        slot_busy[i]   = 1'b0;
        slot_count[i]  = '0;
        slot_handle[i] = '0;
      end
      taken_total = '0;
      lfsr_state  = LFSR_RESET;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THRESHOLD:   threshold = data;
        REG_COUNT_MATCH: count_match_only = data[0];
        REG_SHUFFLE:     shuffle_on = data[0];
        default: ;
      endcase
    endfunction

    // one accepted frame: hold it, or pass it and release what is due
    function void take_frame(logic [HB-1:0] handle, logic match, logic take);
      logic [HB-1:0] batch [DEPTH];
      logic [HB-1:0] tmp;
      int            n;
      int            j;
      out_item_t     o;
      n = 0;
      if (match && take) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!slot_busy[i]) begin
            slot_busy[i]   = 1'b1;
            slot_handle[i] = handle;
            slot_count[i]  = '0;
            taken_total    = taken_total + 1;
            return;
          end
        end
      end
      // advance counts, saturating
      if (!count_match_only || match) begin
        foreach (slot_busy[i]) begin
          if (slot_busy[i] && slot_count[i] != COUNT_MAX)
            slot_count[i] = slot_count[i] + 1'b1;
        end
      end
      // collect the released batch in slot order
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_busy[i] && slot_count[i] >= threshold) begin
          batch[n]     = slot_handle[i];
          n            = n + 1;
          slot_busy[i] = 1'b0;
        end
      end
      // fisher-yates with one lfsr step per draw
      if (shuffle_on) begin
        for (int i = n - 1; i > 0; i--) begin
          lfsr_state = (lfsr_state >> 1) ^ (lfsr_state[0] ? LFSR_TAPS : {LFSR_W{1'b0}});
          j          = int'(lfsr_state % (i + 1));
          tmp        = batch[i];
          batch[i]   = batch[j];
          batch[j]   = tmp;
        end
      end
      o.handle = handle;
      o.reinj  = 1'b0;
      o.last   = (n == 0);
      due_outputs.insert(due_outputs.size(), o);
      for (int i = 0; i < n; i++) begin
        o.handle = batch[i];
        o.reinj  = 1'b1;
        o.last   = (i == n - 1);
        due_outputs.insert(due_outputs.size(), o);
      end
    endfunction

    task flag_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    // compare one result item with the oldest one due
    task match_output(logic [HB-1:0] handle, logic reinj, logic last);
      out_item_t want;
      if (due_outputs.size() == 0) begin
        flag_mismatch($sformatf("unexpected result item, handle %02h", handle));
        return;
      end
      want = due_outputs.pop_front();
      if (handle !== want.handle)
        flag_mismatch($sformatf("out_handle %02h, want %02h", handle, want.handle));
      if (reinj !== want.reinj)
        flag_mismatch($sformatf("reinjected %b, want %b (handle %02h)", reinj, want.reinj,
                                want.handle));
      if (last !== want.last)
        flag_mismatch($sformatf("last_of_run %b, want %b (handle %02h)", last, want.last,
                                want.handle));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  frame_valid;
  logic                  frame_stall;
  logic [HB-1:0]         frame_handle;
  logic                  stream_match;
  logic                  take_request;
  logic                  result_valid;
  logic                  result_stall;
  logic [HB-1:0]         out_handle;
  logic                  reinjected;
  logic                  last_of_run;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  reinject_tracker tracker;
  int snd_idle_pct = 29;
  int rcv_idle_pct = 49;
  int hold_asks    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int cycle_cnt    = 0;

  frame_reorder_injector #(
    .HOLD_DEPTH  (DEPTH),
    .HANDLE_BITS (HB)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_handle (frame_handle),
    .stream_match (stream_match),
    .take_request (take_request),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_handle   (out_handle),
    .reinjected   (reinjected),
    .last_of_run  (last_of_run),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stall: long hold-off on request, else random idling
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      tracker.match_output(out_handle, reinjected, last_of_run);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_frame_reorder_injector: done, errors");
      $finish;
    end
  end

  // offer one frame item and wait until it is taken
  task automatic send_frame(input logic [HB-1:0] h, input logic m, input logic t);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      frame_valid <= 1'b0;
      @(negedge clk);
    end
    frame_valid  <= 1'b1;
    frame_handle <= h;
    stream_match <= m;
    take_request <= t;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    tracker.take_frame(h, m, t);
  endtask

  task automatic send_random_frame();
    send_frame(HB'($urandom_range(255)), $urandom_range(99) < 65, $urandom_range(99) < 45);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    tracker.set_reg(idx, data);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] thr, input logic cm,
                            input logic sh);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_COUNT_MATCH, CFG_DATA_W'(cm));
    write_reg(REG_SHUFFLE, CFG_DATA_W'(sh));
  endtask

  // drop valid, wait for every due result, then let a held frame settle
  task automatic drain_results();
    @(negedge clk);
    frame_valid <= 1'b0;
    while (tracker.due_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // main sequence
  initial begin
    logic [CFG_DATA_W-1:0] thr;
    tracker      = new();
    rst          = 1'b1;
    frame_valid  = 1'b0;
    frame_handle = '0;
    stream_match = 1'b0;
    take_request = 1'b0;
    result_stall = 1'b0;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: zero threshold releases on the next passed frame
    send_frame(8'h00, 1'b0, 1'b0);
    send_frame(8'hFF, 1'b1, 1'b1);
    send_frame(8'h55, 1'b0, 1'b1);
    drain_results();

    // maximum threshold: fill every slot, then a selected frame passes
    set_config(16'hFFFF, 1'b1, 1'b1);
    for (int i = 0; i < DEPTH; i++)
      send_frame(HB'(8'h80 + i * 8'h11), 1'b1, 1'b1);
    send_frame(8'h3C, 1'b1, 1'b1);
    send_frame(8'hC3, 1'b0, 1'b0);
    drain_results();

    // zero threshold: a non-matching frame frees a full shuffled batch
    set_config(16'h0000, 1'b1, 1'b1);
    send_frame(8'h01, 1'b0, 1'b0);
    drain_results();

    // small threshold in slot order, counting every passed frame
    set_config(16'd2, 1'b0, 1'b0);
    send_frame(8'h10, 1'b1, 1'b1);
    send_frame(8'h11, 1'b1, 1'b1);
    send_frame(8'h12, 1'b0, 1'b0);
    send_frame(8'h13, 1'b1, 1'b0);
    drain_results();

    // random phases under the three idle patterns
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      snd_idle_pct = (p < 2) ? 29 : (p < 4) ? 49 : 0;
      rcv_idle_pct = (p < 2) ? 49 : (p < 4) ? 29 : 0;
      case ($urandom_range(3))
        0:       thr = '0;
        3:       thr = CFG_DATA_W'($urandom_range(7, 40));
        default: thr = CFG_DATA_W'($urandom_range(1, 6));
      endcase
      set_config(thr, 1'($urandom_range(1)), 1'($urandom_range(1)));
      if (p == 0)
        hold_asks = hold_asks + 1;
      repeat (PHASE_ITEMS) send_random_frame();
      drain_results();
    end

    if (tracker.mismatches == 0)
      $display("tb_frame_reorder_injector: done, clean");
    else
      $display("tb_frame_reorder_injector: done, errors");
    $finish;
  end

endmodule
